/* rtl/assert_macros.svh */
// Assertion macros included by the placement core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbb assertion failed");

// Next-cycle implication, checked out of reset.
`define RBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbb assertion failed");

`endif

/* rtl/rbb_pkg.sv */
// Shared types, constants and the divider step for the ray/box placement core.
package rbb_pkg;

    localparam int AXES  = 3;
    localparam int DIR_FRAC = 14;
    localparam int T_W   = 48;          // signed ray distance width
    localparam int DVD_W = 47;          // |bound - origin| << 14
    localparam int DIV_N = DVD_W;       // one quotient bit per stage
    localparam int BW    = 16;          // |dir|
    localparam int RW    = 17;          // divider remainder
    localparam int LANE_LAT = DIV_N + 3;

    localparam int TRACE_LENGTH_DEF = 50000;
    localparam int PARALLEL_EPS_DEF = 2;
    localparam int FRAC_BITS_DEF    = 12;

    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 3;
    localparam int ADDR_W     = 5;

    typedef enum logic [2:0] {
        REG_MIN_X     = 3'd0,
        REG_MIN_Y     = 3'd1,
        REG_MIN_Z     = 3'd2,
        REG_MAX_X     = 3'd3,
        REG_MAX_Y     = 3'd4,
        REG_MAX_Z     = 3'd5,
        REG_PRESENT   = 3'd6,
        REG_UNLIMITED = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        NS_WORLD = 2'd0,
        NS_FACE  = 2'd1,
        NS_UP    = 2'd2
    } t_nsrc;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_WORLD = 2'd1,
        K_FACE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [RW-1:0]    rem;
        logic [DVD_W-1:0] dvd;
    } t_dstate;

    typedef struct packed {
        logic neg_min;
        logic neg_max;
        logic par;
        logic pmiss;
    } t_lflags;

    typedef struct packed {
        logic signed [T_W-1:0] lo;
        logic signed [T_W-1:0] hi;
        logic                  min_first;
        logic                  par;
        logic                  pmiss;
    } t_lane_res;

    typedef struct packed {
        logic [AXES-1:0][31:0] org;
        logic [AXES-1:0][15:0] dir;
        logic [AXES-1:0][31:0] hit;
        logic                  whit;
        logic                  hin;
    } t_pay;

    // One restoring-division step: shift in a dividend bit, subtract if it fits.
    function automatic t_dstate div_step(input t_dstate s, input logic [BW-1:0] b);
        logic [RW:0] tmp;
        logic        qb;
        t_dstate     o;
        tmp = {s.rem, s.dvd[DVD_W-1]};
        qb  = (tmp >= {2'b00, b});
        o.rem = qb ? RW'(tmp - {2'b00, b}) : RW'(tmp);
        o.dvd = {s.dvd[DVD_W-2:0], qb};
        return o;
    endfunction

endpackage

/* rtl/rbb_lane.sv */
// One axis lane: slab distances to both bounds through a pipelined divider.
module rbb_lane #(
    parameter int PARALLEL_EPS = rbb_pkg::PARALLEL_EPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_org,
    input  logic signed [15:0]  i_dir,
    input  logic signed [31:0]  i_bmin,
    input  logic signed [31:0]  i_bmax,
    output rbb_pkg::t_lane_res  o_res
);
    import rbb_pkg::*;

    logic signed [32:0] w_dmin, w_dmax;
    logic [32:0]        w_mmin, w_mmax;
    logic [BW-1:0]      w_ad;
    t_lflags            w_fl;

    t_dstate            r_p_min, r_p_max;
    logic [BW-1:0]      r_p_b;
    t_lflags            r_p_fl;

    t_dstate            r_st_min [DIV_N];
    t_dstate            r_st_max [DIV_N];
    logic [BW-1:0]      r_st_b   [DIV_N];
    t_lflags            r_st_fl  [DIV_N];

    logic signed [T_W-1:0] r_n_t1, r_n_t2;
    t_lflags               r_n_fl;
    logic                  w_first;

    assign w_dmin = 33'(i_bmin) - 33'(i_org);
    assign w_dmax = 33'(i_bmax) - 33'(i_org);
    assign w_mmin = w_dmin[32] ? 33'(-w_dmin) : 33'(w_dmin);
    assign w_mmax = w_dmax[32] ? 33'(-w_dmax) : 33'(w_dmax);
    assign w_ad   = i_dir[15] ? BW'(-i_dir) : BW'(i_dir);

    always_comb begin
        w_fl.neg_min = w_dmin[32] ^ i_dir[15];
        w_fl.neg_max = w_dmax[32] ^ i_dir[15];
        w_fl.par     = (w_ad == '0) || (32'(w_ad) < 32'(PARALLEL_EPS));
        w_fl.pmiss   = (i_org < i_bmin) || (i_org > i_bmax);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_min <= '{rem: '0, dvd: {w_mmin, {DIR_FRAC{1'b0}}}};
            r_p_max <= '{rem: '0, dvd: {w_mmax, {DIR_FRAC{1'b0}}}};
            r_p_b   <= w_ad;
            r_p_fl  <= w_fl;
        end
    end

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st_min[k] <= div_step(r_p_min, r_p_b);
                    r_st_max[k] <= div_step(r_p_max, r_p_b);
                    r_st_b[k]   <= r_p_b;
                    r_st_fl[k]  <= r_p_fl;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st_min[k] <= div_step(r_st_min[k-1], r_st_b[k-1]);
                    r_st_max[k] <= div_step(r_st_max[k-1], r_st_b[k-1]);
                    r_st_b[k]   <= r_st_b[k-1];
                    r_st_fl[k]  <= r_st_fl[k-1];
                end
            end
        end
    end

    // quotient magnitude back to a signed distance (truncated toward zero)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_t1 <= r_st_fl[DIV_N-1].neg_min ? -$signed(T_W'(r_st_min[DIV_N-1].dvd))
                                               :  $signed(T_W'(r_st_min[DIV_N-1].dvd));
            r_n_t2 <= r_st_fl[DIV_N-1].neg_max ? -$signed(T_W'(r_st_max[DIV_N-1].dvd))
                                               :  $signed(T_W'(r_st_max[DIV_N-1].dvd));
            r_n_fl <= r_st_fl[DIV_N-1];
        end
    end

    assign w_first = r_n_t1 < r_n_t2;

    // equal distances: max side is the entry side
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.lo        <= w_first ? r_n_t1 : r_n_t2;
            o_res.hi        <= w_first ? r_n_t2 : r_n_t1;
            o_res.min_first <= w_first;
            o_res.par       <= r_n_fl.par;
            o_res.pmiss     <= r_n_fl.pmiss;
        end
    end

endmodule

/* rtl/ray_box_brush_placement_core.sv */
// Ray/box brush placement: three slab lanes, merge, face select, point and output skid.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------
//  s_axis   | in        | tvalid/tready        | ray origin, direction, world hit
//  m_axis   | out       | tvalid/tready        | placement point, normal info
//  apb      | in        | psel/penable/pwrite  | box bounds, present, unlimited
//
// One ray accepted per cycle while the skid word is empty; each axis lane holds a 47-stage
// bit-per-stage slab divider, followed by merge, select and multiply registers.
// Synchronous active-low reset clears config and all valid bits.
// The whole pipeline moves as one; a skid word behind the output register lets
// a new ray enter while a result waits, and the pipeline holds only once it fills.
module ray_box_brush_placement_core #(
    parameter int TRACE_LENGTH = rbb_pkg::TRACE_LENGTH_DEF,
    parameter int PARALLEL_EPS = rbb_pkg::PARALLEL_EPS_DEF,
    parameter int FRAC_BITS    = rbb_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // org_x, org_y, org_z, dir_x, dir_y, dir_z, hit_x, hit_y, hit_z
    input  logic [rbb_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // world_hit
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // place_x, place_y, place_z, face_axis, face_negative, zero pad
    output logic [rbb_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // place_valid, normal_source
    output logic [rbb_pkg::OUT_USER_W-1:0]     o_m_axis_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rbb_pkg::ADDR_W-1:0]         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rbb_pkg::*;

    localparam longint LIMIT_L = longint'(TRACE_LENGTH) * (longint'(1) << FRAC_BITS);
    localparam logic signed [T_W-1:0] LIMIT = T_W'(LIMIT_L);
    localparam int TH_W = $clog2(LIMIT_L + 1);
    localparam int PW   = TH_W + 17;
    localparam int SW   = ((PW - DIR_FRAC) > 32 ? (PW - DIR_FRAC) : 32) + 1;
    localparam logic [PW-1:0] HALF = PW'(1) << (DIR_FRAC - 1);
    localparam int W_D = OUT_DATA_W + OUT_USER_W;

    // configuration
    logic signed [31:0] r_bmin [AXES];
    logic signed [31:0] r_bmax [AXES];
    logic               r_present, r_unl;
    logic               w_cfg_wr;
    t_reg               w_reg;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg    = t_reg'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_bmin[a] <= '0;
                r_bmax[a] <= '0;
            end
            r_present <= 1'b0;
            r_unl     <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_MIN_X:     r_bmin[0] <= pwdata;
                REG_MIN_Y:     r_bmin[1] <= pwdata;
                REG_MIN_Z:     r_bmin[2] <= pwdata;
                REG_MAX_X:     r_bmax[0] <= pwdata;
                REG_MAX_Y:     r_bmax[1] <= pwdata;
                REG_MAX_Z:     r_bmax[2] <= pwdata;
                REG_PRESENT:   r_present <= pwdata[0];
                REG_UNLIMITED: r_unl     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_MIN_X:     prdata = r_bmin[0];
            REG_MIN_Y:     prdata = r_bmin[1];
            REG_MIN_Z:     prdata = r_bmin[2];
            REG_MAX_X:     prdata = r_bmax[0];
            REG_MAX_Y:     prdata = r_bmax[1];
            REG_MAX_Z:     prdata = r_bmax[2];
            REG_PRESENT:   prdata = {31'b0, r_present};
            REG_UNLIMITED: prdata = {31'b0, r_unl};
            default:       prdata = '0;
        endcase
    end

    // input word
    logic   w_adv;
    logic   r_skid_v;
    t_pay   w_in;

    assign w_adv           = !r_skid_v;
    assign o_s_axis_tready = w_adv;

    always_comb begin
        w_in.org  = i_s_axis_tdata[95:0];
        w_in.dir  = i_s_axis_tdata[143:96];
        w_in.hit  = i_s_axis_tdata[239:144];
        w_in.whit = i_s_axis_tuser;
        w_in.hin  = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            if ($signed(w_in.hit[a]) < r_bmin[a] || $signed(w_in.hit[a]) > r_bmax[a])
                w_in.hin = 1'b0;
        end
    end

    // lanes
    t_lane_res w_lane [AXES];

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        rbb_lane #(
            .PARALLEL_EPS (PARALLEL_EPS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_org  ($signed(w_in.org[a])),
            .i_dir  ($signed(w_in.dir[a])),
            .i_bmin (r_bmin[a]),
            .i_bmax (r_bmax[a]),
            .o_res  (w_lane[a])
        );
    end

    // payload delay matched to the lanes
    logic r_v   [LANE_LAT];
    t_pay r_pay [LANE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) r_v[k] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < LANE_LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pay[0] <= w_in;
            for (int k = 1; k < LANE_LAT; k++) r_pay[k] <= r_pay[k-1];
        end
    end

    // merge: entry is the largest near distance, exit the smallest far one;
    // a later axis wins only on strict improvement
    logic                  n_miss, n_any;
    logic signed [T_W-1:0] n_tmin, n_tmax;
    logic [1:0]            n_eax, n_xax;
    logic                  n_emin, n_xmin;

    always_comb begin
        n_miss = 1'b0;
        n_any  = 1'b0;
        n_tmin = '0;
        n_tmax = '0;
        n_eax  = '0;
        n_xax  = '0;
        n_emin = 1'b0;
        n_xmin = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            if (w_lane[a].par) begin
                if (w_lane[a].pmiss) n_miss = 1'b1;
            end else begin
                if (!n_any || w_lane[a].lo > n_tmin) begin
                    n_tmin = w_lane[a].lo;
                    n_eax  = 2'(a);
                    n_emin = w_lane[a].min_first;
                end
                if (!n_any || w_lane[a].hi < n_tmax) begin
                    n_tmax = w_lane[a].hi;
                    n_xax  = 2'(a);
                    n_xmin = !w_lane[a].min_first;
                end
                n_any = 1'b1;
            end
        end
    end

    logic                  r_m_v, r_m_miss, r_m_any;
    logic signed [T_W-1:0] r_m_tmin, r_m_tmax;
    logic [1:0]            r_m_eax, r_m_xax;
    logic                  r_m_emin, r_m_xmin;
    t_pay                  r_m_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_m_v <= 1'b0;
        else if (w_adv) r_m_v <= r_v[LANE_LAT-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_miss <= n_miss;
            r_m_any  <= n_any;
            r_m_tmin <= n_tmin;
            r_m_tmax <= n_tmax;
            r_m_eax  <= n_eax;
            r_m_xax  <= n_xax;
            r_m_emin <= n_emin;
            r_m_xmin <= n_xmin;
            r_m_pay  <= r_pay[LANE_LAT-1];
        end
    end

    // select world hit or face point
    logic                  w_box_hit;
    t_kind                 n_kind;
    logic signed [T_W-1:0] n_th;
    logic [1:0]            n_ax;
    logic                  n_neg;

    // with no slab axis the span is unbounded, so a present box "hits" unless unlimited or missed
    assign w_box_hit = !r_unl && r_present && !r_m_miss
                       && (!r_m_any || r_m_tmin <= r_m_tmax);

    always_comb begin
        n_kind = K_NONE;
        n_th   = '0;
        n_ax   = '0;
        n_neg  = 1'b0;
        if (r_m_pay.whit && (r_unl || (w_box_hit && r_m_pay.hin))) begin
            n_kind = K_WORLD;
        end else if (w_box_hit && r_m_any) begin
            if (r_m_tmin < 0 && r_m_tmax > 0) begin
                n_th  = r_m_tmax;
                n_ax  = r_m_xax;
                n_neg = !r_m_xmin;
                n_kind = K_FACE;
            end else if (r_m_tmin >= 0) begin
                n_th  = r_m_tmin;
                n_ax  = r_m_eax;
                n_neg = !r_m_emin;
                n_kind = K_FACE;
            end
            if (n_th > LIMIT) n_kind = K_NONE;
        end
    end

    logic             r_s_v;
    t_kind            r_s_kind;
    logic [TH_W-1:0]  r_s_th;
    logic [1:0]       r_s_ax;
    logic             r_s_neg;
    t_pay             r_s_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_s_v <= 1'b0;
        else if (w_adv) r_s_v <= r_m_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_kind <= n_kind;
            r_s_th   <= n_th[TH_W-1:0];
            r_s_ax   <= n_ax;
            r_s_neg  <= n_neg;
            r_s_pay  <= r_m_pay;
        end
    end

    // dir * t per axis
    logic                       r_x_v;
    t_kind                      r_x_kind;
    logic signed [PW-1:0]       r_x_prod [AXES];
    logic [1:0]                 r_x_ax;
    logic                       r_x_neg;
    t_pay                       r_x_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_x_v <= 1'b0;
        else if (w_adv) r_x_v <= r_s_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < AXES; a++)
                r_x_prod[a] <= PW'($signed(r_s_pay.dir[a]) * $signed({1'b0, r_s_th}));
            r_x_kind <= r_s_kind;
            r_x_ax   <= r_s_ax;
            r_x_neg  <= r_s_neg;
            r_x_pay  <= r_s_pay;
        end
    end

    // round to nearest (ties up), add origin, saturate
    logic signed [PW-1:0] w_rnd [AXES];
    logic signed [SW-1:0] w_sum [AXES];
    logic [AXES-1:0][31:0] w_pt;
    logic [OUT_DATA_W-1:0] w_end_data;
    logic [OUT_USER_W-1:0] w_end_user;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_rnd[a] = (r_x_prod[a] + $signed(HALF)) >>> DIR_FRAC;
            w_sum[a] = SW'($signed(r_x_pay.org[a])) + SW'(w_rnd[a]);
            if (w_sum[a][SW-1:31] == '0 || w_sum[a][SW-1:31] == '1)
                w_pt[a] = w_sum[a][31:0];
            else
                w_pt[a] = w_sum[a][SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
    end

    always_comb begin
        w_end_data = '0;
        w_end_user = '0;
        case (r_x_kind)
            K_WORLD: begin
                w_end_data[95:0] = r_x_pay.hit;
                w_end_user       = {NS_WORLD, 1'b1};
            end
            K_FACE: begin
                w_end_data[95:0]  = w_pt;
                w_end_data[97:96] = r_x_ax;
                w_end_data[98]    = r_x_neg;
                w_end_user        = {NS_FACE, 1'b1};
            end
            default: ;
        endcase
    end

    // output register plus skid word
    logic                  r_out_v;
    logic [W_D-1:0]        r_out_d, r_skid_d;
    logic                  w_taken;

    assign w_taken = r_out_v && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_taken) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || w_taken) begin
            r_out_v <= r_x_v;
        end else if (r_x_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_taken) r_out_d <= r_skid_d;
        end else if (!r_out_v || w_taken) begin
            r_out_d <= {w_end_user, w_end_data};
        end else begin
            r_skid_d <= {w_end_user, w_end_data};
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_d[OUT_DATA_W-1:0];
    assign o_m_axis_tuser  = r_out_d[W_D-1:OUT_DATA_W];

    `include "assert_macros.svh"

    `RBB_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `RBB_ASSERT_IMPL(a_invalid_is_zero, i_clk, i_rst_n, r_out_v && !o_m_axis_tuser[0], o_m_axis_tdata == '0 && o_m_axis_tuser == '0)
    `RBB_ASSERT_IMPL(a_no_up_vector, i_clk, i_rst_n, r_out_v, o_m_axis_tuser[2:1] != NS_UP)
    `RBB_ASSERT_IMPL(a_axis_code, i_clk, i_rst_n, r_out_v, o_m_axis_tdata[97:96] != 2'd3)
    `RBB_ASSERT_NEXT(a_skid_stalls_input, i_clk, i_rst_n, r_out_v && !i_m_axis_tready && r_x_v && !r_skid_v, !o_s_axis_tready)

endmodule
